[hw/rtl/sli_pkg.sv]
// Shared types and constants for the sorted list insert/remove block.
// Used by sli_cmp, sli_ctrl and the top level; has no dependencies of its own.
`default_nettype none

package sli_pkg;

  localparam int VALUE_BITS   = 16;
  localparam int COUNT_BITS   = 7;
  localparam int DEF_CAPACITY = 64;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef struct packed {
    op_e                           op;
    logic signed [VALUE_BITS-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_e                       status;
    logic [COUNT_BITS-1:0]         entry_count;
    logic signed [VALUE_BITS-1:0]  smallest;
    logic signed [VALUE_BITS-1:0]  largest;
  } out_item_t;

  // Result of the shared compare unit.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

`default_nettype wire

[hw/rtl/sli_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/sli_cmp.sv]
// Shared signed compare unit: less-than and equal of a stored entry against the item value.
// Depends on sli_pkg.
`default_nettype none

module sli_cmp (
  input  wire logic signed [sli_pkg::VALUE_BITS-1:0] a_i,
  input  wire logic signed [sli_pkg::VALUE_BITS-1:0] b_i,
  output sli_pkg::cmp_t                              res_o
);

  always_comb begin
    res_o.lt = (a_i < b_i);
    res_o.eq = (a_i == b_i);
  end

endmodule

`default_nettype wire

[hw/rtl/sli_ctrl.sv]
// Sequencer for the sorted list: walks the entry RAM one entry per step,
// shifting entries up on insert and down on remove. Depends on sli_pkg, sli_cmp.
`default_nettype none

module sli_ctrl #(
  parameter int CAPACITY = sli_pkg::DEF_CAPACITY
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire sli_pkg::in_item_t                    in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output sli_pkg::out_item_t                        out_data_o,
  output logic                                      ram_we_o,
  output logic [$clog2(CAPACITY)-1:0]               ram_waddr_o,
  output logic [sli_pkg::VALUE_BITS-1:0]            ram_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]               ram_raddr_o,
  input  wire logic [sli_pkg::VALUE_BITS-1:0]       ram_rdata_i
);

  localparam int AddrW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int VB    = sli_pkg::VALUE_BITS;
  localparam int CB    = sli_pkg::COUNT_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_REM_RD,
    S_REM_CHK,
    S_SHF_RD,
    S_SHF_WR,
    S_FIN0,
    S_FIN1,
    S_FIN2,
    S_OUT
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         occ_q, occ_d;
  logic [CntW-1:0]         idx_q, idx_d;
  logic signed [VB-1:0]    value_q, value_d;
  sli_pkg::status_e        status_q, status_d;
  logic signed [VB-1:0]    small_q, small_d;
  logic signed [VB-1:0]    large_q, large_d;

  logic [CntW-1:0]         idx_inc;
  logic [CntW-1:0]         idx_dec;
  logic [CntW-1:0]         occ_last;
  logic [CntW+CB-1:0]      count_ext;
  sli_pkg::cmp_t           cmp;

  sli_cmp u_cmp (
    .a_i   ($signed(ram_rdata_i)),
    .b_i   (value_q),
    .res_o (cmp)
  );

  assign idx_inc  = idx_q + CntW'(1);
  assign idx_dec  = idx_q - CntW'(1);
  assign occ_last = occ_q - CntW'(1);

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    value_d     = value_q;
    status_d    = status_q;
    small_d     = small_q;
    large_d     = large_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q[AddrW-1:0];
    ram_wdata_o = value_q;
    ram_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          value_d  = in_data_i.value;
          status_d = sli_pkg::ST_DONE;
          if (in_data_i.op == sli_pkg::OP_INSERT) begin
            if (occ_q == CntW'(CAPACITY)) begin
              status_d = sli_pkg::ST_FULL;
              state_d  = S_FIN0;
            end else begin
              idx_d   = occ_q;
              state_d = S_INS_RD;
            end
          end else begin
            idx_d   = '0;
            state_d = S_REM_RD;
          end
        end
      end
      // Insert walks down from the top, moving each entry not below the value up one.
      S_INS_RD: begin
        if (idx_q == '0) begin
          ram_we_o = 1'b1;
          occ_d    = occ_q + CntW'(1);
          state_d  = S_FIN0;
        end else begin
          ram_raddr_o = idx_dec[AddrW-1:0];
          state_d     = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        ram_we_o = 1'b1;
        if (cmp.lt) begin
          occ_d   = occ_q + CntW'(1);
          state_d = S_FIN0;
        end else begin
          ram_wdata_o = ram_rdata_i;
          idx_d       = idx_dec;
          state_d     = S_INS_RD;
        end
      end
      S_REM_RD: begin
        if (idx_q == occ_q) begin
          status_d = sli_pkg::ST_MISSING;
          state_d  = S_FIN0;
        end else begin
          ram_raddr_o = idx_q[AddrW-1:0];
          state_d     = S_REM_CHK;
        end
      end
      S_REM_CHK: begin
        if (cmp.eq) begin
          state_d = S_SHF_RD;
        end else begin
          idx_d   = idx_inc;
          state_d = S_REM_RD;
        end
      end
      // Close the gap left by the removed entry.
      S_SHF_RD: begin
        if (idx_inc == occ_q) begin
          occ_d   = occ_last;
          state_d = S_FIN0;
        end else begin
          ram_raddr_o = idx_inc[AddrW-1:0];
          state_d     = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        idx_d       = idx_inc;
        state_d     = S_SHF_RD;
      end
      S_FIN0: begin
        if (occ_q == '0) begin
          small_d = '0;
          large_d = '0;
          state_d = S_OUT;
        end else begin
          ram_raddr_o = '0;
          state_d     = S_FIN1;
        end
      end
      S_FIN1: begin
        small_d     = $signed(ram_rdata_i);
        ram_raddr_o = occ_last[AddrW-1:0];
        state_d     = S_FIN2;
      end
      S_FIN2: begin
        large_d = $signed(ram_rdata_i);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      occ_q    <= '0;
      idx_q    <= '0;
      status_q <= sli_pkg::ST_DONE;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      idx_q    <= idx_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    small_q <= small_d;
    large_q <= large_d;
  end

  // Count is reported modulo 128.
  assign count_ext   = (CntW + CB)'(occ_q);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    out_data_o.status      = status_q;
    out_data_o.entry_count = count_ext[CB-1:0];
    out_data_o.smallest    = small_q;
    out_data_o.largest     = large_q;
  end

endmodule

`default_nettype wire

[hw/rtl/sorted_list_insert_remove.sv]
// Top level of the sorted list: entry RAM plus its walking sequencer.
// Depends on sli_pkg, sli_ram, sli_cmp, sli_ctrl.
//
//   channel  direction  handshake                    payload
//   in       input      in_valid_i / in_stall_o      in_data_i  (sli_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i    out_data_o (sli_pkg::out_item_t)
//
// One item at a time: each entry walked costs a read step and a check/write step
// on the entry RAM, and smallest and largest are then fetched unless it is empty.
// A dropped insert walks no entries, nor does a remove on an empty store.
// Reset clears the count, index, state and status only; the RAM needs no clearing pass.
// in_stall_o stays high until the result item has been taken.
`default_nettype none

module sorted_list_insert_remove #(
  parameter int CAPACITY = sli_pkg::DEF_CAPACITY
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sli_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sli_pkg::out_item_t      out_data_o
);

  localparam int AddrW = $clog2(CAPACITY);

  logic                            ram_we;
  logic [AddrW-1:0]                ram_waddr;
  logic [sli_pkg::VALUE_BITS-1:0]  ram_wdata;
  logic [AddrW-1:0]                ram_raddr;
  logic [sli_pkg::VALUE_BITS-1:0]  ram_rdata;

  sli_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  sli_ram #(
    .WIDTH (sli_pkg::VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

[tb/sorted_list_insert_remove_tb.sv]
// Self-checking testbench for sorted_list_insert_remove: random and directed
// insert/remove items checked against a queue-based copy of the ordered store.
// Depends on sli_pkg and the sorted_list_insert_remove RTL only.
`timescale 1ns / 1ps

module sorted_list_insert_remove_tb;
  import sli_pkg::*;

  localparam int CAPACITY    = DEF_CAPACITY;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 2 * CAPACITY + 20;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_PRINTS  = 40;

  localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = 16'sh7FFF;
  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = 16'sh8000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  // copy of the ordered store, ascending
  logic signed [VALUE_BITS-1:0] sorted_copy[$];
  out_item_t expected_results[$];

  int  error_count   = 0;
  int  results_seen  = 0;
  int  cycle_count   = 0;
  int  items_sent    = 0;
  int  inserts_sent  = 0;
  int  removes_sent  = 0;
  int  full_drops    = 0;
  int  absent_misses = 0;
  int  max_fill      = 0;
  bit  tx_idle_en    = 1'b1;
  bit  rx_idle_en    = 1'b1;
  bit  hold_request  = 1'b0;

  sorted_list_insert_remove #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("sorted_list_insert_remove_tb: FAIL");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2, 3:    return 16'($urandom_range(0, 15) + 65528);  // -8..7, forces ties
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_remove_value();
    if (sorted_copy.size() != 0 && $urandom_range(0, 3) != 0)
      return sorted_copy[$urandom_range(0, sorted_copy.size() - 1)];
    return pick_value();
  endfunction

  function automatic out_item_t predict_list_op(input op_e item_op,
                                                input logic signed [VALUE_BITS-1:0] item_value);
    out_item_t r;
    int pos;
    r.status = ST_DONE;
    pos = 0;
    if (item_op == OP_INSERT) begin
      if (sorted_copy.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        while (pos < sorted_copy.size() && sorted_copy[pos] < item_value) pos++;
        sorted_copy.insert(pos, item_value);
      end
    end else begin
      while (pos < sorted_copy.size() && sorted_copy[pos] != item_value) pos++;
      if (pos >= sorted_copy.size()) r.status = ST_MISSING;
      else sorted_copy.delete(pos);
    end
    r.entry_count = COUNT_BITS'(sorted_copy.size());
    if (sorted_copy.size() == 0) begin
      r.smallest = '0;
      r.largest  = '0;
    end else begin
      r.smallest = sorted_copy[0];
      r.largest  = sorted_copy[sorted_copy.size() - 1];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("[%0t] result %0d: %s got %0d expected %0d", $time, results_seen, what,
               got, want);
  endtask

  // Entered right after a rising edge; returns at the edge that accepts the item.
  // Valid stays high when the next item follows with no gap.
  task automatic send_item(input op_e item_op, input logic signed [VALUE_BITS-1:0] item_value);
    int gap;
    out_item_t want;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{op: item_op, value: item_value};
    do @(posedge clk_i); while (in_stall_o);
    want = predict_list_op(item_op, item_value);
    expected_results.push_back(want);
    items_sent++;
    if (item_op == OP_INSERT) inserts_sent++;
    else removes_sent++;
    if (want.status == ST_FULL) full_drops++;
    if (want.status == ST_MISSING) absent_misses++;
    if (sorted_copy.size() > max_fill) max_fill = sorted_copy.size();
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, or one long counted hold on request
  initial begin : result_receiver
    int n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      n = rx_idle_en ? pick_gap() : 0;
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", out_data_o.status, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_data_o.entry_count, want.entry_count);
        if (out_data_o.smallest !== want.smallest)
          report_mismatch("smallest", out_data_o.smallest, want.smallest);
        if (out_data_o.largest !== want.largest)
          report_mismatch("largest", out_data_o.largest, want.largest);
      end
    end
  end

  task automatic test_empty_store();
    send_item(OP_REMOVE, 16'sd0);
    send_item(OP_REMOVE, VALUE_MIN);
  endtask

  task automatic test_value_extremes();
    send_item(OP_INSERT, VALUE_MAX);
    send_item(OP_INSERT, VALUE_MIN);
    send_item(OP_INSERT, 16'sd0);
    send_item(OP_INSERT, -16'sd1);
    send_item(OP_INSERT, 16'sd1);
    send_item(OP_INSERT, VALUE_MAX);
    send_item(OP_REMOVE, VALUE_MAX);
    send_item(OP_REMOVE, 16'sd100);
    send_item(OP_REMOVE, VALUE_MIN);
    send_item(OP_REMOVE, 16'sd0);
    send_item(OP_REMOVE, -16'sd1);
    send_item(OP_REMOVE, 16'sd1);
    send_item(OP_REMOVE, VALUE_MAX);
    send_item(OP_REMOVE, VALUE_MAX);
  endtask

  task automatic test_duplicates();
    send_item(OP_INSERT, 16'sd5);
    send_item(OP_INSERT, 16'sd5);
    send_item(OP_INSERT, -16'sd5);
    send_item(OP_INSERT, 16'sd5);
    repeat (2) send_item(OP_REMOVE, 16'sd5);
    send_item(OP_REMOVE, -16'sd5);
    repeat (2) send_item(OP_REMOVE, 16'sd5);
  endtask

  task automatic test_fill_and_overflow();
    while (sorted_copy.size() < CAPACITY) begin
      if ($urandom_range(0, 99) < 85) send_item(OP_INSERT, pick_value());
      else send_item(OP_REMOVE, pick_remove_value());
    end
    repeat (12) begin
      if ($urandom_range(0, 3) != 0) send_item(OP_INSERT, pick_value());
      else send_item(OP_REMOVE, 16'($urandom()));
    end
  endtask

  task automatic test_drain_to_empty();
    int r;
    while (sorted_copy.size() > 0) begin
      r = $urandom_range(0, 99);
      if (r < 80) send_item(OP_REMOVE, sorted_copy[$urandom_range(0, sorted_copy.size() - 1)]);
      else if (r < 95) send_item(OP_REMOVE, pick_value());
      else send_item(OP_INSERT, pick_value());
    end
    repeat (3) send_item(OP_REMOVE, pick_value());
  endtask

  task automatic test_random_mix(input int count);
    int insert_pct;
    repeat (count) begin
      if (sorted_copy.size() < 16) insert_pct = 70;
      else if (sorted_copy.size() > 48) insert_pct = 30;
      else insert_pct = 50;
      if ($urandom_range(0, 99) < insert_pct) send_item(OP_INSERT, pick_value());
      else send_item(OP_REMOVE, pick_remove_value());
    end
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    tx_idle_en   = 1'b0;
    hold_request = 1'b1;
    test_random_mix(15);
    tx_idle_en   = 1'b1;
    wait_all_results();
  endtask

  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_mix(100);
    wait_all_results();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (4) begin
      test_random_mix(10);
      wait_all_results();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_value_extremes();
    test_duplicates();
    wait_all_results();

    repeat (2) begin
      test_fill_and_overflow();
      test_drain_to_empty();
      wait_all_results();
    end
    test_random_mix(500);
    test_backpressure();
    test_no_idle();
    test_sender_pause();

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d items (%0d inserts, %0d removes), %0d results checked.",
             items_sent, inserts_sent, removes_sent, results_seen);
    $display("Store filled to %0d; %0d inserts dropped while full, %0d removes of absent values.",
             max_fill, full_drops, absent_misses);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("sorted_list_insert_remove_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results still pending", error_count,
               expected_results.size());
      $display("sorted_list_insert_remove_tb: FAIL");
    end
    $finish;
  end

endmodule
